/* rtl/core/dqls_pkg.sv */
// ----------------------------------------------------------------------------
// dqls_pkg
// Shared types, sizes and helpers for the double-ended queue with search.
// ----------------------------------------------------------------------------
package dqls_pkg;

    localparam int DEPTH   = 16;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 5;
    localparam int OCC_W   = 5;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [POS_W-1:0] NO_POSITION = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  pos;
        logic [OCC_W-1:0]  occ;
    } t_result;

    // (ptr + off) mod DEPTH, both operands below DEPTH
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, ptr} + {1'b0, off};
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

/* rtl/core/dqls_ram.sv */
// ----------------------------------------------------------------------------
// dqls_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dqls_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH_P-1:0]                       i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] i_rd_addr,
    output logic [WIDTH_P-1:0]                       o_rd_data
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/dqls_ctrl.sv */
// ----------------------------------------------------------------------------
// dqls_ctrl
// Command sequencer: ring pointers, push/pop writes and the search scan
// over the entry store.
// ----------------------------------------------------------------------------
module dqls_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  dqls_pkg::t_cmd          i_cmd,
    input  logic [dqls_pkg::DATA_W-1:0] i_value,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output dqls_pkg::t_result       o_res
);

    import dqls_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_front, n_front;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PTR_W-1:0]    r_idx,   n_idx;
    logic [DATA_W-1:0]   r_key,   n_key;
    t_status             r_status, n_status;
    logic [POS_W-1:0]    r_pos,   n_pos;

    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic [DATA_W-1:0]   rd_data;
    logic [PTR_W-1:0]    idx_next;

    assign idx_next = r_idx + PTR_W'(1);

    dqls_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_key    = r_key;
        n_status = r_status;
        n_pos    = r_pos;
        wr_en    = 1'b0;
        wr_addr  = r_front;
        rd_en    = 1'b0;
        rd_addr  = r_front;
        o_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_status = ST_OK;
                    n_pos    = NO_POSITION;
                    n_state  = S_DONE;
                    case (i_cmd)
                        CMD_PUSH_FRONT: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? PTR_W'(DEPTH - 1)
                                                          : r_front - PTR_W'(1);
                                wr_en   = 1'b1;
                                wr_addr = n_front;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = ring_add(r_front, r_count[PTR_W-1:0]);
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front = ring_add(r_front, PTR_W'(1));
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_key   = i_value;
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_data == r_key) begin
                    n_status = ST_OK;
                    n_pos    = POS_W'(r_idx);
                    n_state  = S_DONE;
                end else if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ring_add(r_front, idx_next);
                    n_idx   = idx_next;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    assign o_res.status = r_status;
    assign o_res.pos    = r_pos;
    assign o_res.occ    = OCC_W'(r_count);

endmodule

/* rtl/core/deque_with_linear_search.sv */
// ----------------------------------------------------------------------------
// deque_with_linear_search
// Bounded double-ended queue of signed 32-bit words with a front-first search.
// Push and pop: one item at a time; the result is registered in the sequencer,
// then in the output register. Search: one entry compared per cycle off the
// store's single registered read port, up to the stored count of entries.
// Output register frees the sequencer while a result waits for tready.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
module deque_with_linear_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [dqls_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] item_value
    input  logic [dqls_pkg::CMD_W-1:0]     s_tuser,  // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [dqls_pkg::M_TDATA_W-1:0] m_tdata,  // [4:0] found_position,
                                                      // [9:5] occupancy, rest 0
    output logic [dqls_pkg::STAT_W-1:0]    m_tuser   // [1:0] status
);

    import dqls_pkg::*;

    logic     res_valid;
    logic     res_ready;
    t_result  res;
    logic     r_out_valid;
    t_result  r_out;

    dqls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_cmd       (t_cmd'(s_tuser)),
        .i_value     (s_tdata[DATA_W-1:0]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.status;
    assign m_tdata  = {(M_TDATA_W - POS_W - OCC_W)'(0), r_out.occ, r_out.pos};

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[9:5] <= OCC_W'(DEPTH)))
        else $error("occupancy above depth");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[9:5] == OCC_W'(DEPTH)))
        else $error("full status with room left");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[9:5] == '0))
        else $error("empty status with entries stored");

    a_pos_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[4:0] != NO_POSITION) |->
            (m_tuser == ST_OK && m_tdata[4:0] < m_tdata[9:5]))
        else $error("found position outside stored window");

endmodule

/* dv/deque_with_linear_search_check.sv */
// ----------------------------------------------------------------------------
// deque_with_linear_search_check
// Watches both stream channels of the deque. On every accepted command word it
// updates its own copy of the queue and works out the expected result word;
// every result word is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module deque_with_linear_search_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [dqls_pkg::S_TDATA_W-1:0] i_s_tdata,   // [31:0] item_value
    input  logic [dqls_pkg::CMD_W-1:0]     i_s_tuser,   // [2:0] command
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [dqls_pkg::M_TDATA_W-1:0] i_m_tdata,   // [4:0] found_position,
                                                        // [9:5] occupancy
    input  logic [dqls_pkg::STAT_W-1:0]    i_m_tuser,   // [1:0] status
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_full_drops,
    output int                             o_empty_pops,
    output int                             o_hits,
    output int                             o_misses
);
    timeunit 1ns;
    timeprecision 1ps;

    import dqls_pkg::*;

    logic [DATA_W-1:0] shadow_ring [DEPTH];
    int                shadow_head;
    int                shadow_fill;
    t_result           awaited_results [$];
    int                errors, checked, full_drops, empty_pops, hits, misses;

    initial begin
        errors = 0;
        checked = 0;
        full_drops = 0;
        empty_pops = 0;
        hits = 0;
        misses = 0;
        o_errors = 0;
        o_pending = 0;
        o_checked = 0;
        o_full_drops = 0;
        o_empty_pops = 0;
        o_hits = 0;
        o_misses = 0;
    end

    function automatic t_result apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [DATA_W-1:0] key);
        t_result res;
        res.status = ST_OK;
        res.pos    = NO_POSITION;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = key;
                    shadow_fill++;
                end
            end
            CMD_PUSH_BACK: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_ring[(shadow_head + shadow_fill) % DEPTH] = key;
                    shadow_fill++;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                end
            end
            CMD_POP_BACK: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_fill--;
                end
            end
            CMD_SEARCH: begin
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_ring[(shadow_head + i) % DEPTH] == key) begin
                        res.status = ST_OK;
                        res.pos    = POS_W'(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.occ = OCC_W'(shadow_fill);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            shadow_head = 0;
            shadow_fill = 0;
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tuser);
                got.pos    = i_m_tdata[POS_W-1:0];
                got.occ    = i_m_tdata[POS_W +: OCC_W];
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%t: unexpected result word status=%0d pos=%0d occ=%0d",
                                 $realtime, got.status, got.pos, got.occ);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (got.status !== want.status || got.pos !== want.pos
                        || got.occ !== want.occ) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%t: mismatch exp status=%0d pos=%0d occ=%0d",
                                     $realtime, want.status, want.pos, want.occ);
                            $display("%t:          got status=%0d pos=%0d occ=%0d",
                                     $realtime, got.status, got.pos, got.occ);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = apply_command(i_s_tuser, i_s_tdata[DATA_W-1:0]);
                if (want.status == ST_FULL) full_drops++;
                if (want.status == ST_EMPTY) empty_pops++;
                if (i_s_tuser == CMD_SEARCH) begin
                    if (want.status == ST_OK) hits++;
                    else misses++;
                end
                awaited_results.push_back(want);
            end
        end
        o_errors     <= errors;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
        o_full_drops <= full_drops;
        o_empty_pops <= empty_pops;
        o_hits       <= hits;
        o_misses     <= misses;
    end

endmodule

/* dv/deque_with_linear_search_test.sv */
// ----------------------------------------------------------------------------
// deque_with_linear_search_test
// Drives command words into the deque: a directed opening on the extremes and
// corner cases, then random bursts that swing the queue between empty and
// full, with random idling on both channels, a long output stall and a full
// drain pause. The checker beside the block does all result comparison.
// ----------------------------------------------------------------------------
module deque_with_linear_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dqls_pkg::*;

    localparam int RANDOM_WORDS = 430;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [31:0] item_value
    logic [CMD_W-1:0]     s_tuser  = '0;   // [2:0] command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [4:0] found_position, [9:5] occupancy
    logic [STAT_W-1:0]    m_tuser;         // [1:0] status

    int errors, pending, checked, full_drops, empty_pops, hits, misses;
    int sent_cnt = 0;
    bit no_idle  = 1'b0;
    bit stalled  = 1'b0;
    logic [DATA_W-1:0] key_pool [8];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    deque_with_linear_search uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    deque_with_linear_search_check checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_drops (full_drops),
        .o_empty_pops (empty_pops),
        .o_hits       (hits),
        .o_misses     (misses)
    );

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        no_idle = (sent_cnt >= 200 && sent_cnt < 280);
        while (!no_idle && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        sent_cnt++;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(3) == 0) return $urandom;
        return key_pool[$urandom_range(7)];
    endfunction

    // receiver: random backpressure, one long hold-off mid-run
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (!stalled && sent_cnt >= 150) begin
                stalled = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            m_tready <= no_idle || ($urandom_range(99) >= 27);
            @(posedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int r, mode, push_pct, pop_pct;
        logic [CMD_W-1:0] cmd;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening
        send_word(CMD_SEARCH,     32'h0000_0005);
        send_word(CMD_POP_FRONT,  $urandom);
        send_word(CMD_POP_BACK,   $urandom);
        send_word(CMD_PUSH_BACK,  32'h7FFF_FFFF);
        send_word(CMD_PUSH_FRONT, 32'h8000_0000);
        send_word(CMD_PUSH_BACK,  32'h0000_0000);
        send_word(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_word(CMD_PUSH_BACK,  32'h7FFF_FFFF);
        send_word(CMD_SEARCH,     32'h7FFF_FFFF);
        send_word(CMD_SEARCH,     32'h8000_0000);
        send_word(CMD_SEARCH,     32'hFFFF_FFFF);
        send_word(CMD_SEARCH,     32'h0000_0000);
        send_word(CMD_SEARCH,     32'h0001_2345);
        send_word(CMD_SEARCH + 3'd1, $urandom);
        send_word(CMD_SEARCH + 3'd2, $urandom);
        send_word(CMD_SEARCH + 3'd3, $urandom);
        send_word(CMD_POP_FRONT,  $urandom);
        send_word(CMD_POP_BACK,   $urandom);
        send_word(CMD_SEARCH,     32'h7FFF_FFFF);
        send_word(CMD_POP_BACK,   $urandom);
        send_word(CMD_POP_FRONT,  $urandom);
        send_word(CMD_POP_FRONT,  $urandom);
        send_word(CMD_POP_BACK,   $urandom);
        send_word(CMD_SEARCH,     32'hFFFF_FFFF);

        // random bursts: fill-heavy, drain-heavy or balanced
        mode = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 35 == 0) mode = $urandom_range(2);
            if (n == 320) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            case (mode)
                0:       begin push_pct = 60; pop_pct = 15; end
                1:       begin push_pct = 15; pop_pct = 60; end
                default: begin push_pct = 35; pop_pct = 35; end
            endcase
            r = $urandom_range(99);
            if (r < 5) begin
                cmd = CMD_SEARCH + 3'($urandom_range(3, 1));
            end else if (r < 5 + push_pct) begin
                cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            end else if (r < 5 + push_pct + pop_pct) begin
                cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
            end else begin
                cmd = CMD_SEARCH;
            end
            send_word(cmd, pick_value());
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d command words, checked %0d results.", sent_cnt, checked);
        $display("Full drops %0d, empty pops %0d, search hits %0d, misses %0d.",
                 full_drops, empty_pops, hits, misses);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
